@@ rtl/core/srt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted region table package
// Shared item types, field widths, operation and status codes.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam int unsigned CAP_W         = 7;
  localparam int unsigned POS_W         = 6;
  localparam int unsigned COUNT_W       = 7;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic ST_DONE = 1'b0;
  localparam logic ST_FULL = 1'b1;

  typedef struct packed {
    logic        action;
    logic [63:0] image_base;
    logic [31:0] image_size;
    logic [63:0] unwind_address;
    logic [31:0] unwind_size;
  } srt_req_t;

  typedef struct packed {
    logic               status;
    logic               matched;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] entry_count;
    logic               overflow_seen;
  } srt_res_t;

  typedef struct packed {
    logic [63:0] base;
    logic [31:0] isize;
    logic [63:0] unwind;
    logic [31:0] usize;
  } srt_entry_t;

endpackage

@@ rtl/core/srt_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted region table storage
// One write port and one registered read port over DEPTH records.
// ----------------------------------------------------------------------------
module srt_mem import srt_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  srt_entry_t               wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output srt_entry_t               rdata_o
);

  srt_entry_t mem_q [DEPTH];
  srt_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/srt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted region table sequencer
// Walks the table one entry per cycle through a single compare unit, then
// shifts entries up or down through the memory ports and writes any new entry.
// ----------------------------------------------------------------------------
module srt_ctrl import srt_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  srt_req_t                 req_i,
  input  logic [CAP_W-1:0]         cap_i,
  output logic                     busy_o,
  output logic                     done_o,
  output srt_res_t                 res_o,
  output logic                     mem_we_o,
  output logic [$clog2(DEPTH)-1:0] mem_waddr_o,
  output srt_entry_t               mem_wdata_o,
  output logic [$clog2(DEPTH)-1:0] mem_raddr_o,
  input  srt_entry_t               mem_rdata_i
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_WRITE
  } state_e;

  state_e          state_q, state_d;
  srt_req_t        item_q, item_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic [AW-1:0]   ptr_q, ptr_d;
  logic [AW-1:0]   pos_q, pos_d;
  logic            done_q, done_d;
  srt_res_t        res_q, res_d;

  logic [CMP_W-1:0] limit;
  logic             full;
  logic             hit;
  logic             last_cmp;
  srt_entry_t       rec_item;

  always_comb begin
    limit = (CMP_W'(cap_i) < CMP_W'(DEPTH)) ? CMP_W'(cap_i) : CMP_W'(DEPTH);
    full  = CMP_W'(cnt_q) >= limit;
  end

  // shared compare unit: key order on insert, address match on remove
  always_comb begin
    if (item_q.action == OP_INSERT) begin
      hit = item_q.image_base < mem_rdata_i.base;
    end else begin
      hit = mem_rdata_i.unwind == item_q.unwind_address;
    end
    last_cmp = (CW'(ptr_q) + CW'(1)) == cnt_q;
    rec_item = '{base:   item_q.image_base,
                 isize:  item_q.image_size,
                 unwind: item_q.unwind_address,
                 usize:  item_q.unwind_size};
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    ptr_d       = ptr_q;
    pos_d       = pos_q;
    done_d      = 1'b0;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = ptr_q;
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          item_d = req_i;
          if (req_i.action == OP_INSERT) begin
            if (full) begin
              ovf_d  = 1'b1;
              done_d = 1'b1;
              res_d  = '{status: ST_FULL, matched: 1'b0, position: '0,
                         entry_count: COUNT_W'(cnt_q), overflow_seen: 1'b1};
            end else if (cnt_q == '0) begin
              pos_d   = '0;
              state_d = S_WRITE;
            end else if (cnt_q == CW'(1)) begin
              pos_d   = AW'(1);
              state_d = S_WRITE;
            end else begin
              ptr_d       = AW'(1);
              mem_raddr_o = AW'(1);
              state_d     = S_SEARCH;
            end
          end else begin
            if (cnt_q == '0) begin
              done_d = 1'b1;
              res_d  = '{status: ST_DONE, matched: 1'b0, position: '0,
                         entry_count: COUNT_W'(cnt_q), overflow_seen: ovf_q};
            end else begin
              ptr_d       = '0;
              mem_raddr_o = '0;
              state_d     = S_SEARCH;
            end
          end
        end
      end

      S_SEARCH: begin
        if (hit) begin
          pos_d = ptr_q;
          if (item_q.action == OP_INSERT) begin
            ptr_d       = AW'(cnt_q - CW'(1));
            mem_raddr_o = AW'(cnt_q - CW'(1));
            state_d     = S_SHIFT_UP;
          end else if (last_cmp) begin
            cnt_d   = cnt_q - CW'(1);
            done_d  = 1'b1;
            res_d   = '{status: ST_DONE, matched: 1'b1, position: POS_W'(ptr_q),
                        entry_count: COUNT_W'(cnt_q - CW'(1)), overflow_seen: ovf_q};
            state_d = S_IDLE;
          end else begin
            ptr_d       = ptr_q + AW'(1);
            mem_raddr_o = ptr_q + AW'(1);
            state_d     = S_SHIFT_DN;
          end
        end else if (last_cmp) begin
          if (item_q.action == OP_INSERT) begin
            pos_d   = AW'(cnt_q);
            state_d = S_WRITE;
          end else begin
            done_d  = 1'b1;
            res_d   = '{status: ST_DONE, matched: 1'b0, position: '0,
                        entry_count: COUNT_W'(cnt_q), overflow_seen: ovf_q};
            state_d = S_IDLE;
          end
        end else begin
          ptr_d       = ptr_q + AW'(1);
          mem_raddr_o = ptr_q + AW'(1);
        end
      end

      S_SHIFT_UP: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ptr_q + AW'(1);
        if (ptr_q == pos_q) begin
          state_d = S_WRITE;
        end else begin
          ptr_d       = ptr_q - AW'(1);
          mem_raddr_o = ptr_q - AW'(1);
        end
      end

      S_SHIFT_DN: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ptr_q - AW'(1);
        if (last_cmp) begin
          cnt_d   = cnt_q - CW'(1);
          done_d  = 1'b1;
          res_d   = '{status: ST_DONE, matched: 1'b1, position: POS_W'(pos_q),
                      entry_count: COUNT_W'(cnt_q - CW'(1)), overflow_seen: ovf_q};
          state_d = S_IDLE;
        end else begin
          ptr_d       = ptr_q + AW'(1);
          mem_raddr_o = ptr_q + AW'(1);
        end
      end

      S_WRITE: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_q;
        mem_wdata_o = rec_item;
        cnt_d       = cnt_q + CW'(1);
        done_d      = 1'b1;
        res_d       = '{status: ST_DONE, matched: 1'b1, position: POS_W'(pos_q),
                        entry_count: COUNT_W'(cnt_q + CW'(1)), overflow_seen: ovf_q};
        state_d     = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    ptr_q  <= ptr_d;
    pos_q  <= pos_d;
    res_q  <= res_d;
  end

  assign busy_o = state_q != S_IDLE;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ rtl/core/sorted_region_table_insert_remove.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted region table with insert and remove
// Keeps image records ordered by base from position 1 on and inserts or removes one per command.
// ----------------------------------------------------------------------------
// An insert or remove walks the stored entries through the single table read
// port one per cycle, first to search and then to shift, so the time grows
// with the entry count. A refused insert and a remove on an empty table finish
// from idle without raising busy. busy stays high until the command completes;
// done_o is high for one cycle with the result on res_o, which must be taken
// then; res_o holds it until the next result.
// ----------------------------------------------------------------------------
module sorted_region_table_insert_remove import srt_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  srt_req_t         req_i,
  output logic             done_o,
  output srt_res_t         res_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CAP_W-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [CAP_W-1:0] cap_q;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [AW-1:0]    mem_raddr;
  srt_entry_t       mem_wdata;
  srt_entry_t       mem_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAPACITY_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  srt_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start && !busy),
    .req_i       (req_i),
    .cap_i       (cap_q),
    .busy_o      (busy),
    .done_o      (done_o),
    .res_o       (res_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  srt_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  a_full_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.status == ST_FULL |-> !res_o.matched && res_o.overflow_seen)
    else $error("refused insert reported a match");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || done_o)
    else $error("accepted command neither busy nor done");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result while still busy");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !mem_we)
    else $error("table written while idle");

endmodule

@@ verif/tb_sorted_region_table_insert_remove.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted region table insert/remove testbench
// Drives insert and remove commands across several capacity settings. A
// directed table covers an empty table, a single entry, appends, duplicate
// bases, removes with and without a match, refused inserts and the capacity
// extremes. Random commands follow, mixing inserts and removes; most removes
// name stored unwind addresses and inserts fill the table. Every result is
// checked against the bench's table model or a given expected result.
// ----------------------------------------------------------------------------
module tb_sorted_region_table_insert_remove;
  import srt_pkg::*;

  localparam int unsigned DEPTH = DEPTH_DEFAULT;

  typedef struct {
    bit               is_cfg;
    logic [CAP_W-1:0] cap;
    srt_req_t         op;
    bit               typed;
    srt_res_t         want;
  } script_row_t;

  typedef struct {
    logic [CAP_W-1:0] cap;
    int unsigned      insert_pct;
    int unsigned      count;
  } phase_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  srt_req_t         req_i;
  logic             done_o;
  srt_res_t         res_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CAP_W-1:0] cfg_data_i;

  srt_entry_t       region_model [DEPTH];
  int unsigned      region_total;
  logic             overflow_model;
  logic [CAP_W-1:0] capacity_model;

  srt_res_t         pending_outcomes [$];
  srt_res_t         oldest_outcome;
  script_row_t      directed_rows [$];
  int unsigned      mismatches;
  int unsigned      sender_idle_pct;

  sorted_region_table_insert_remove #(.DEPTH(DEPTH)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic srt_res_t apply_table_op(input srt_req_t op);
    srt_res_t    r;
    int unsigned lim;
    int unsigned pos;
    int unsigned i;
    r = '0;
    r.status = ST_DONE;
    lim = (capacity_model < DEPTH) ? capacity_model : DEPTH;
    if (op.action == OP_INSERT) begin
      if (region_total >= lim) begin
        overflow_model = 1'b1;
        r.status = ST_FULL;
      end else begin
        pos = 0;
        if (region_total != 0) begin
          pos = 1;
          while (pos < region_total && !(op.image_base < region_model[pos].base))
            pos++;
        end
        for (i = region_total; i > pos; i--)
          region_model[i] = region_model[i-1];
        region_model[pos].base   = op.image_base;
        region_model[pos].isize  = op.image_size;
        region_model[pos].unwind = op.unwind_address;
        region_model[pos].usize  = op.unwind_size;
        region_total++;
        r.matched  = 1'b1;
        r.position = pos[POS_W-1:0];
      end
    end else begin
      pos = 0;
      while (pos < region_total && region_model[pos].unwind != op.unwind_address)
        pos++;
      if (pos < region_total) begin
        for (i = pos; i + 1 < region_total; i++)
          region_model[i] = region_model[i+1];
        region_total--;
        r.matched  = 1'b1;
        r.position = pos[POS_W-1:0];
      end
    end
    r.entry_count   = region_total[COUNT_W-1:0];
    r.overflow_seen = overflow_model;
    return r;
  endfunction

  function automatic srt_req_t random_op(input int unsigned insert_pct);
    srt_req_t op;
    op.action = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
    case ($urandom_range(7))
      0:       op.image_base = '0;
      1:       op.image_base = '1;
      2, 3:    op.image_base = 64'($urandom_range(15));
      default: op.image_base = {$urandom, $urandom};
    endcase
    op.image_size     = $urandom;
    op.unwind_size    = $urandom;
    op.unwind_address = {$urandom, $urandom};
    if (region_total != 0) begin
      if (op.action == OP_REMOVE && $urandom_range(3) != 0)
        op.unwind_address = region_model[$urandom_range(region_total-1)].unwind;
      else if (op.action == OP_INSERT && $urandom_range(9) == 0)
        op.unwind_address = region_model[$urandom_range(region_total-1)].unwind;
    end
    return op;
  endfunction

  function automatic script_row_t op_row(input logic act, input logic [63:0] base,
                                         input logic [31:0] isize,
                                         input logic [63:0] unwind,
                                         input logic [31:0] usize,
                                         input bit typed = 1'b0,
                                         input srt_res_t want = '0);
    script_row_t row;
    row.is_cfg               = 1'b0;
    row.cap                  = '0;
    row.op.action            = act;
    row.op.image_base        = base;
    row.op.image_size        = isize;
    row.op.unwind_address    = unwind;
    row.op.unwind_size       = usize;
    row.typed                = typed;
    row.want                 = want;
    return row;
  endfunction

  function automatic script_row_t cfg_row(input logic [CAP_W-1:0] cap);
    script_row_t row;
    row        = op_row(OP_INSERT, '0, '0, '0, '0);
    row.is_cfg = 1'b1;
    row.cap    = cap;
    return row;
  endfunction

  task automatic flag_mismatch(input string field, input logic [63:0] got,
                               input logic [63:0] want);
    if (mismatches < 100)
      $display("mismatch %s: got %0h want %0h at %0t ns", field, got, want, $time);
    mismatches++;
  endtask

  task automatic drive_item(input srt_req_t op, input bit typed, input srt_res_t want);
    srt_res_t predicted;
    int unsigned gap;
    gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 4) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= op;
    do @(posedge clk_i); while (busy);
    predicted = apply_table_op(op);
    pending_outcomes.push_back(typed ? want : predicted);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    do @(posedge clk_i); while (busy);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    capacity_model = cap;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_outcomes.size() == 0) begin
        flag_mismatch("unexpected result", 64'(res_o), 64'd0);
      end else begin
        oldest_outcome = pending_outcomes.pop_front();
        if (res_o.status !== oldest_outcome.status)
          flag_mismatch("status", 64'(res_o.status), 64'(oldest_outcome.status));
        if (res_o.matched !== oldest_outcome.matched)
          flag_mismatch("matched", 64'(res_o.matched), 64'(oldest_outcome.matched));
        if (res_o.position !== oldest_outcome.position)
          flag_mismatch("position", 64'(res_o.position), 64'(oldest_outcome.position));
        if (res_o.entry_count !== oldest_outcome.entry_count)
          flag_mismatch("entry_count", 64'(res_o.entry_count),
                        64'(oldest_outcome.entry_count));
        if (res_o.overflow_seen !== oldest_outcome.overflow_seen)
          flag_mismatch("overflow_seen", 64'(res_o.overflow_seen),
                        64'(oldest_outcome.overflow_seen));
      end
    end
  end

  initial begin
    #(20_000_000);
    $display("sorted_region_table_insert_remove regression: fail");
    $finish;
  end

  initial begin
    phase_t      plan [10];
    script_row_t row;
    int unsigned p;
    int unsigned n;

    start          = 1'b0;
    req_i          = '0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    rst_ni         = 1'b0;
    region_total   = 0;
    overflow_model = 1'b0;
    capacity_model = CAPACITY_RESET;
    mismatches     = 0;
    sender_idle_pct = 12;

    directed_rows.push_back(op_row(OP_REMOVE, '0, '0, '0, '0, 1'b1,
                                   srt_res_t'({ST_DONE, 1'b0, 6'd0, 7'd0, 1'b0})));
    directed_rows.push_back(op_row(OP_INSERT, '1, '1, '1, '1, 1'b1,
                                   srt_res_t'({ST_DONE, 1'b1, 6'd0, 7'd1, 1'b0})));
    directed_rows.push_back(op_row(OP_INSERT, '0, '0, '0, '0, 1'b1,
                                   srt_res_t'({ST_DONE, 1'b1, 6'd1, 7'd2, 1'b0})));
    directed_rows.push_back(op_row(OP_INSERT, 64'h8000_0000_0000_0000, 32'h1234_5678,
                                   64'h1000, 32'h8000_0000));
    directed_rows.push_back(op_row(OP_INSERT, 64'h10, 32'h5555_5555,
                                   64'h2000, 32'hAAAA_AAAA));
    directed_rows.push_back(op_row(OP_INSERT, 64'h0, 32'hAAAA_AAAA,
                                   64'h3000, 32'h5555_5555));
    directed_rows.push_back(op_row(OP_REMOVE, '0, '0, 64'h2000, '0));
    directed_rows.push_back(op_row(OP_REMOVE, '0, '0, 64'hDEAD_BEEF, '0));
    directed_rows.push_back(op_row(OP_REMOVE, '0, '0, '1, '0));
    directed_rows.push_back(cfg_row(7'd1));
    directed_rows.push_back(op_row(OP_INSERT, 64'h5, 32'h1, 64'h4000, 32'h1, 1'b1,
                                   srt_res_t'({ST_FULL, 1'b0, 6'd0, 7'd3, 1'b1})));
    directed_rows.push_back(cfg_row(7'd0));
    directed_rows.push_back(op_row(OP_REMOVE, '0, '0, 64'h0, '0));
    directed_rows.push_back(op_row(OP_INSERT, 64'h6, 32'h2, 64'h4100, 32'h2));
    directed_rows.push_back(cfg_row(7'd127));
    directed_rows.push_back(op_row(OP_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_0000,
                                   64'h5000, 32'h0000_FFFF));
    directed_rows.push_back(cfg_row(7'd64));
    directed_rows.push_back(op_row(OP_REMOVE, '0, '0, 64'h1000, '0));
    directed_rows.push_back(op_row(OP_REMOVE, '0, '0, 64'h3000, '0));
    directed_rows.push_back(op_row(OP_REMOVE, '0, '0, 64'h5000, '0));
    directed_rows.push_back(op_row(OP_REMOVE, '0, '0, 64'h5000, '0));
    directed_rows.push_back(op_row(OP_INSERT, 64'h0, 32'h0, 64'h6000, 32'h0));
    directed_rows.push_back(op_row(OP_INSERT, 64'h0, 32'h0, 64'h6000, 32'h0));

    plan[0] = '{7'd64,  75, 200};
    plan[1] = '{7'd64,  30, 150};
    plan[2] = '{7'd1,   50,  60};
    plan[3] = '{7'd37,  60, 150};
    plan[4] = '{7'd2,   50,  60};
    plan[5] = '{7'd64,  70, 200};
    plan[6] = '{7'd127, 60, 120};
    plan[7] = '{7'd0,   40,  60};
    plan[8] = '{7'd64,  50, 200};
    plan[9] = '{7'd64,  45, 180};

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg)
        write_capacity(row.cap);
      else
        drive_item(row.op, row.typed, row.want);
    end

    for (p = 0; p < 10; p++) begin
      case (p * 3 / 10)
        0:       sender_idle_pct = 12;
        1:       sender_idle_pct = 60;
        default: sender_idle_pct = 0;
      endcase
      write_capacity(plan[p].cap);
      for (n = 0; n < plan[p].count; n++)
        drive_item(random_op(plan[p].insert_pct), 1'b0, '0);
    end

    wait_idle();
    repeat (DEPTH + 4) @(posedge clk_i);
    if (pending_outcomes.size() != 0)
      flag_mismatch("missing results", 64'(pending_outcomes.size()), 64'd0);
    if (mismatches == 0)
      $display("sorted_region_table_insert_remove regression: pass");
    else
      $display("sorted_region_table_insert_remove regression: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/srt_pkg.sv
rtl/core/srt_mem.sv
rtl/core/srt_ctrl.sv
rtl/core/sorted_region_table_insert_remove.sv
verif/tb_sorted_region_table_insert_remove.sv
